/* sv/skf_pkg.sv */
// Shared types, codes and control store for the scalar Kalman filter.
`timescale 1ns / 1ps

package skf_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int COV_W       = 32;
    localparam int STEP_W      = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_NOISE = CFG_INDEX_W'(1);

    localparam logic [COV_W-1:0] PROCESS_NOISE_RESET = 32'd655;
    localparam logic [COV_W-1:0] MEASURE_NOISE_RESET = 32'd65536;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_PRED,
        OP_DEN,
        OP_NUM,
        OP_DIV,
        OP_GAIN,
        OP_MUL,
        OP_EST,
        OP_COMMIT
    } skf_op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN,
        COND_CNT,
        COND_OUT
    } skf_cond_t;

    typedef struct packed {
        skf_op_t           op;
        skf_cond_t         cond;
        logic [STEP_W-1:0] target;
    } skf_ctrl_t;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIV    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_COMMIT = 4'd8;

    function automatic skf_ctrl_t skf_rom(input logic [STEP_W-1:0] step);
        skf_ctrl_t w;
        case (step)
            4'd0:    w = '{op: OP_LOAD,   cond: COND_IN,   target: STEP_IDLE};
            4'd1:    w = '{op: OP_PRED,   cond: COND_NONE, target: STEP_IDLE};
            4'd2:    w = '{op: OP_DEN,    cond: COND_NONE, target: STEP_IDLE};
            4'd3:    w = '{op: OP_NUM,    cond: COND_NONE, target: STEP_IDLE};
            4'd4:    w = '{op: OP_DIV,    cond: COND_CNT,  target: STEP_DIV};
            4'd5:    w = '{op: OP_GAIN,   cond: COND_NONE, target: STEP_IDLE};
            4'd6:    w = '{op: OP_MUL,    cond: COND_NONE, target: STEP_IDLE};
            4'd7:    w = '{op: OP_EST,    cond: COND_NONE, target: STEP_IDLE};
            4'd8:    w = '{op: OP_COMMIT, cond: COND_OUT,  target: STEP_IDLE};
            default: w = '{op: OP_LOAD,   cond: COND_IN,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/skf_in_if.sv */
// Sample input channel: valid, ready and one measurement.
`timescale 1ns / 1ps

interface skf_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

/* sv/skf_out_if.sv */
// Result channel: valid, ready, estimate and gain.
`timescale 1ns / 1ps

interface skf_out_if #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int GAIN_WIDTH   = 17
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] estimate;
    logic        [GAIN_WIDTH-1:0]   gain;

    modport source (output valid, output estimate, output gain, input ready);
    modport sink   (input valid, input estimate, input gain, output ready);
endinterface

/* sv/skf_cfg_if.sv */
// Configuration write channel: valid, ready, register index and data.
`timescale 1ns / 1ps

interface skf_cfg_if;
    import skf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/scalar_kalman_filter.sv */
// Scalar Kalman filter top level, microcoded sequencer over a shared datapath.
// A sample taken in the load step passes through the predict, denominator, numerator, divide, gain,
// multiply, estimate and commit steps; the divide step yields one quotient bit per cycle.
// A finished result waits in the output register; the next sample is taken once it is loaded.
// Reset clears estimate and covariance, loads noise defaults and restarts at step zero.
`timescale 1ns / 1ps

module scalar_kalman_filter #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    skf_in_if.sink    samples,
    skf_out_if.source results,
    skf_cfg_if.sink   cfg
);
    import skf_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int F   = GAIN_FRAC_BITS;
    localparam int GW  = F + 1;
    localparam int NW  = COV_W + 1 + F;
    localparam int PW1 = F + SW + 3;
    localparam int PW2 = GW + COV_W;
    localparam int CW  = $clog2(F + 1);

    localparam logic [GW-1:0]  GAIN_ONE = GW'(1) << F;
    localparam logic [PW1:0]   HALF1    = (PW1 + 1)'(1) << (F - 1);
    localparam logic [PW2:0]   HALF2    = (PW2 + 1)'(1) << (F - 1);
    localparam logic signed [PW1:0] SMP_MAX_W =
        $signed({{(PW1 + 2 - SW){1'b0}}, {(SW - 1){1'b1}}});
    localparam logic signed [PW1:0] SMP_MIN_W = ~SMP_MAX_W;

    skf_ctrl_t         ctrl;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              in_xfer;
    logic              out_free;
    logic              commit;
    logic              out_valid_reg, out_valid_next;

    logic [COV_W-1:0]     q_reg, r_reg;
    logic signed [SW-1:0] prior_reg, prior_next;
    logic [COV_W-1:0]     cov_reg, cov_next;

    logic signed [SW-1:0] meas_reg, meas_next;
    logic [COV_W-1:0]     pm_reg, pm_next;
    logic [COV_W:0]       den_reg, den_next;
    logic [COV_W:0]       rem_reg, rem_next;
    logic [GW-1:0]        nlo_reg, nlo_next;
    logic [GW-1:0]        quo_reg, quo_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [GW-1:0]        gain_reg, gain_next;
    logic signed [SW:0]   inn_reg, inn_next;
    logic signed [PW1-1:0] prod1_reg, prod1_next;
    logic [PW2-1:0]       prod2_reg, prod2_next;
    logic signed [SW-1:0] est_reg, est_next;
    logic signed [SW-1:0] res_est_reg;
    logic [GW-1:0]        res_gain_reg;

    logic [COV_W:0]       pred_sum;
    logic [NW-1:0]        num_val;
    logic [COV_W+1:0]     trial;
    logic [COV_W+1:0]     trial_diff;
    logic                 trial_ge;
    logic signed [PW1:0]  rnd_sum;
    logic signed [PW1:0]  rnd_sh;
    logic signed [PW1:0]  est_wide;
    logic [PW2:0]         cov_sum;
    logic [PW2:0]         cov_sh;

    assign ctrl     = skf_rom(step_reg);
    assign in_xfer  = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign commit   = (ctrl.op == OP_COMMIT) && out_free;

    assign samples.ready    = (ctrl.op == OP_LOAD);
    assign cfg.ready        = 1'b1;
    assign results.valid    = out_valid_reg;
    assign results.estimate = res_est_reg;
    assign results.gain     = res_gain_reg;

    always_comb
    begin
        case (ctrl.cond)
            COND_NONE: step_next = step_reg + STEP_W'(1);
            COND_IN:   step_next = in_xfer ? step_reg + STEP_W'(1) : step_reg;
            COND_CNT:  step_next = (cnt_reg != '0) ? ctrl.target : step_reg + STEP_W'(1);
            COND_OUT:  step_next = out_free ? ctrl.target : step_reg;
            default:   step_next = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pred_sum   = {1'b0, cov_reg} + {1'b0, q_reg};
        num_val    = {1'b0, pm_reg, {F{1'b0}}} + {(NW - COV_W)'(0), den_reg[COV_W:1]};
        trial      = {rem_reg, nlo_reg[GW-1]};
        trial_ge   = trial >= {1'b0, den_reg};
        trial_diff = trial - {1'b0, den_reg};
        rnd_sum    = $signed({prod1_reg[PW1-1], prod1_reg}) + $signed(HALF1);
        rnd_sh     = rnd_sum >>> F;
        est_wide   = rnd_sh + $signed({{(PW1 + 1 - SW){prior_reg[SW-1]}}, prior_reg});
        cov_sum    = {1'b0, prod2_reg} + HALF2;
        cov_sh     = cov_sum >> F;

        meas_next  = meas_reg;
        pm_next    = pm_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        gain_next  = gain_reg;
        inn_next   = inn_reg;
        prod1_next = prod1_reg;
        prod2_next = prod2_reg;
        est_next   = est_reg;
        prior_next = prior_reg;
        cov_next   = cov_reg;

        case (ctrl.op)
            OP_LOAD:
            begin
                meas_next = samples.measurement;
            end
            OP_PRED:
            begin
                pm_next = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
            end
            OP_DEN:
            begin
                den_next = {1'b0, pm_reg} + {1'b0, r_reg};
            end
            OP_NUM:
            begin
                rem_next = {1'b0, num_val[NW-1:GW]};
                nlo_next = num_val[GW-1:0];
                quo_next = '0;
                cnt_next = CW'(F);
            end
            OP_DIV:
            begin
                rem_next = trial_ge ? trial_diff[COV_W:0] : trial[COV_W:0];
                quo_next = {quo_reg[GW-2:0], trial_ge};
                nlo_next = {nlo_reg[GW-2:0], 1'b0};
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            OP_GAIN:
            begin
                if (den_reg == '0)
                begin
                    gain_next = '0;
                end
                else if (quo_reg > GAIN_ONE)
                begin
                    gain_next = GAIN_ONE;
                end
                else
                begin
                    gain_next = quo_reg;
                end
                inn_next = $signed({meas_reg[SW-1], meas_reg})
                         - $signed({prior_reg[SW-1], prior_reg});
            end
            OP_MUL:
            begin
                prod1_next = $signed({1'b0, gain_reg}) * inn_reg;
            end
            OP_EST:
            begin
                if (est_wide > SMP_MAX_W)
                begin
                    est_next = SMP_MAX_W[SW-1:0];
                end
                else if (est_wide < SMP_MIN_W)
                begin
                    est_next = SMP_MIN_W[SW-1:0];
                end
                else
                begin
                    est_next = est_wide[SW-1:0];
                end
                prod2_next = (GAIN_ONE - gain_reg) * pm_reg;
            end
            OP_COMMIT:
            begin
                if (out_free)
                begin
                    prior_next = est_reg;
                    cov_next   = (|cov_sh[PW2:COV_W]) ? '1 : cov_sh[COV_W-1:0];
                end
            end
            default:
            begin
                meas_next = meas_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            q_reg         <= PROCESS_NOISE_RESET;
            r_reg         <= MEASURE_NOISE_RESET;
            prior_reg     <= '0;
            cov_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            prior_reg     <= prior_next;
            cov_reg       <= cov_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_PROCESS_NOISE)
                begin
                    q_reg <= cfg.data;
                end
                else if (cfg.index == REG_MEASURE_NOISE)
                begin
                    r_reg <= cfg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg  <= meas_next;
        pm_reg    <= pm_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        nlo_reg   <= nlo_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        gain_reg  <= gain_next;
        inn_reg   <= inn_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        est_reg   <= est_next;
        if (commit)
        begin
            res_est_reg  <= est_reg;
            res_gain_reg <= gain_reg;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_COMMIT)
        else $error("sequencer step out of range");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> step_reg != STEP_IDLE)
        else $error("sequencer did not leave idle after sample transfer");

    a_load_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == OP_COMMIT))
        else $error("result raised outside the commit step");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_gain_reg <= GAIN_ONE)
        else $error("gain above one");

    a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> cov_reg <= $past(pm_reg))
        else $error("covariance grew past the prediction");

endmodule

/* verif/skf_checker.sv */
// Checker for the scalar Kalman filter: tracks filter state, predicts and compares each result.
`timescale 1ns / 1ps

module skf_checker #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    skf_in_if    smp,
    skf_out_if   res,
    skf_cfg_if   cfg,
    output int   estimates_due,
    output int   mismatch_count
);
    import skf_pkg::*;

    localparam int          GAIN_WIDTH = GAIN_FRAC_BITS + 1;
    localparam logic [63:0] GAIN_ONE   = 64'd1 << GAIN_FRAC_BITS;
    localparam longint      GAIN_HALF  = longint'(1) << (GAIN_FRAC_BITS - 1);
    localparam longint      SAMPLE_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint      SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam logic [63:0] COV_MAX    = 64'hFFFF_FFFF;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] estimate;
        logic        [GAIN_WIDTH-1:0]   gain;
    } skf_result_t;

    skf_result_t                    pending_estimates[$];
    logic [COV_W-1:0]               q_noise;
    logic [COV_W-1:0]               r_noise;
    logic signed [SAMPLE_WIDTH-1:0] estimate_prior;
    logic [COV_W-1:0]               covariance;
    int                             error_total;

    function automatic skf_result_t kalman_update(input logic signed [SAMPLE_WIDTH-1:0] meas);
        logic [63:0] pm;
        logic [63:0] den;
        logic [63:0] g;
        logic [63:0] cv;
        longint      inn;
        longint      acc;
        longint      est;
        skf_result_t r;
        pm = {32'd0, covariance} + {32'd0, q_noise};
        if (pm > COV_MAX)
            pm = COV_MAX;
        den = pm + {32'd0, r_noise};
        if (den == 64'd0)
            g = 64'd0;
        else
            g = ((pm << GAIN_FRAC_BITS) + (den >> 1)) / den;
        if (g > GAIN_ONE)
            g = GAIN_ONE;
        inn = longint'(meas) - longint'(estimate_prior);
        acc = longint'(g) * inn + GAIN_HALF;
        est = longint'(estimate_prior) + (acc >>> GAIN_FRAC_BITS);
        if (est > SAMPLE_MAX)
            est = SAMPLE_MAX;
        if (est < SAMPLE_MIN)
            est = SAMPLE_MIN;
        cv = ((GAIN_ONE - g) * pm + 64'(GAIN_HALF)) >> GAIN_FRAC_BITS;
        if (cv > COV_MAX)
            cv = COV_MAX;
        estimate_prior = est[SAMPLE_WIDTH-1:0];
        covariance     = cv[COV_W-1:0];
        r.estimate     = est[SAMPLE_WIDTH-1:0];
        r.gain         = g[GAIN_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        skf_result_t want;
        if (!rst_n)
        begin
            q_noise        = PROCESS_NOISE_RESET;
            r_noise        = MEASURE_NOISE_RESET;
            estimate_prior = '0;
            covariance     = '0;
            error_total    = 0;
            pending_estimates.delete();
            estimates_due  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (pending_estimates.size() == 0)
                begin
                    $error("unexpected result: estimate %0d gain %0d",
                           res.estimate, res.gain);
                    error_total++;
                end
                else
                begin
                    want = pending_estimates.pop_front();
                    if (want.estimate !== res.estimate)
                    begin
                        $error("estimate: expected %0d, got %0d",
                               $signed(want.estimate), res.estimate);
                        error_total++;
                    end
                    if (want.gain !== res.gain)
                    begin
                        $error("gain: expected %0d, got %0d", want.gain, res.gain);
                        error_total++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PROCESS_NOISE: q_noise = cfg.data;
                    REG_MEASURE_NOISE: r_noise = cfg.data;
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
                pending_estimates.push_back(kalman_update(smp.measurement));
            estimates_due  <= pending_estimates.size();
            mismatch_count <= error_total;
        end
    end

endmodule

/* verif/tb_scalar_kalman_filter.sv */
// Testbench top for the scalar Kalman filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
    import skf_pkg::*;

    localparam int          SAMPLE_WIDTH   = 16;
    localparam int          GAIN_FRAC_BITS = 16;
    localparam int          GAIN_WIDTH     = GAIN_FRAC_BITS + 1;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_ITEMS    = 219;
    localparam int          DRAIN_CYCLES   = 2 * (GAIN_FRAC_BITS + 9);
    localparam int          SMP_MAX        = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam int          SMP_MIN        = -SMP_MAX - 1;
    localparam logic [31:0] NOISE_MAX      = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    int   estimates_due;
    int   mismatch_count;
    int   burst_left;
    bit   no_gaps;

    skf_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) smp ();
    skf_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .GAIN_WIDTH(GAIN_WIDTH)) res ();
    skf_cfg_if cfg_ch ();

    scalar_kalman_filter #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(smp),
        .results(res),
        .cfg    (cfg_ch)
    );

    skf_checker #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .smp           (smp),
        .res           (res),
        .cfg           (cfg_ch),
        .estimates_due (estimates_due),
        .mismatch_count(mismatch_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(input int v);
        int c;
        c = v;
        if (c > SMP_MAX)
            c = SMP_MAX;
        if (c < SMP_MIN)
            c = SMP_MIN;
        return c[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return NOISE_MAX;
            2:       return 32'($urandom_range(0, 1023));
            3:       return 32'($urandom);
            4:       return 32'($urandom_range(1, 16)) << 16;
            default: return 32'($urandom) >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] m);
        int gap;
        if (burst_left == 0)
        begin
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                smp.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        smp.valid       <= 1'b1;
        smp.measurement <= m;
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        smp.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (estimates_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_phase();
        int done;
        int len;
        int kind;
        int level;
        int amp;
        int v;
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            kind    = $urandom_range(0, 9);
            len     = $urandom_range(8, 60);
            if (len > PHASE_ITEMS - done)
                len = PHASE_ITEMS - done;
            no_gaps = ($urandom_range(0, 4) == 0);
            level   = int'($urandom_range(0, 65535)) - 32768;
            amp     = 1 << $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
            begin
                if (kind <= 5)
                begin
                    // hold a level with noise, and step it now and then
                    if ($urandom_range(0, 19) == 0)
                        level = int'($urandom_range(0, 65535)) - 32768;
                    v = level + int'($urandom_range(0, 2 * amp)) - amp;
                end
                else if (kind <= 7)
                    v = int'($urandom_range(0, 65535)) - 32768;
                else if (kind == 8)
                begin
                    case ($urandom_range(0, 3))
                        0:       v = SMP_MAX;
                        1:       v = SMP_MIN;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                end
                else
                    v = (i % 2 == 0) ? SMP_MAX : SMP_MIN;
                send_sample(to_sample(v));
            end
            done += len;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int mode;
        int span;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= 1'($urandom_range(0, 1));
                    2:       res.ready <= ($urandom_range(0, 7) == 0);
                    default: res.ready <= ($urandom_range(0, 31) != 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        smp.valid          <= 1'b0;
        smp.measurement    <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        burst_left = 0;
        no_gaps    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset noise values, extreme samples
        send_sample(to_sample(SMP_MAX));
        send_sample(to_sample(SMP_MIN));
        send_sample(to_sample(SMP_MAX));
        send_sample(to_sample(0));
        send_sample(to_sample(-1));
        send_sample(to_sample(1));

        // no noise at all: one step of full gain, then a zero denominator
        wait_idle();
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASURE_NOISE, 32'd0);
        send_sample(to_sample(1234));
        send_sample(to_sample(SMP_MIN));
        send_sample(to_sample(SMP_MAX));
        send_sample(to_sample(5));

        // saturated prediction with half gain, odd innovations hit the rounding half
        wait_idle();
        write_reg(REG_PROCESS_NOISE, NOISE_MAX);
        write_reg(REG_MEASURE_NOISE, NOISE_MAX);
        send_sample(to_sample(SMP_MAX));
        send_sample(to_sample(SMP_MIN));
        send_sample(to_sample(3));
        send_sample(to_sample(-4));
        send_sample(to_sample(0));

        // no process noise with full measurement noise, so the gain falls; writes to unused indexes are dropped
        wait_idle();
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASURE_NOISE, NOISE_MAX);
        write_reg(CFG_INDEX_W'(2), 32'($urandom));
        write_reg({CFG_INDEX_W{1'b1}}, 32'($urandom));
        send_sample(to_sample(SMP_MIN));
        send_sample(to_sample(SMP_MAX));
        send_sample(to_sample(100));

        // saturated prediction with no measurement noise: gain of one
        wait_idle();
        write_reg(REG_PROCESS_NOISE, NOISE_MAX);
        write_reg(REG_MEASURE_NOISE, 32'd0);
        send_sample(to_sample(SMP_MAX));
        send_sample(to_sample(SMP_MIN));

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            if (p == 0)
            begin
                write_reg(REG_PROCESS_NOISE, PROCESS_NOISE_RESET);
                write_reg(REG_MEASURE_NOISE, MEASURE_NOISE_RESET);
            end
            else
            begin
                write_reg(REG_PROCESS_NOISE, pick_noise());
                write_reg(REG_MEASURE_NOISE, pick_noise());
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(2, 255)), 32'($urandom));
            run_random_phase();
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
sv/skf_pkg.sv
sv/skf_in_if.sv
sv/skf_out_if.sv
sv/skf_cfg_if.sv
sv/scalar_kalman_filter.sv
verif/skf_checker.sv
verif/tb_scalar_kalman_filter.sv
